// ===== sv/vtv_pkg.sv =====
// ----------------------------------------------------------------------------
// vtv_pkg: shared definitions for the vertex transform and viewport block
// Field widths, divider step count, opcodes and register indexes.
// ----------------------------------------------------------------------------
package vtv_pkg;

	// field widths
	localparam int COORD_W = 32;
	localparam int COLOR_W = 8;
	localparam int VP_W    = 12;
	localparam int WIN_W   = 13;

	// configuration port address width (seven word registers)
	localparam int REG_AW  = 5;

	// quotient bits resolved per divider stage
	localparam int DIV_K   = 4;

	// item opcodes
	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_VERTEX = 1'b1
	} op_t;

	// register indexes, word address bits [4:2]
	typedef enum logic [2:0] {
		REG_DRAW  = 3'd0,
		REG_VP_X  = 3'd1,
		REG_VP_Y  = 3'd2,
		REG_VP_W  = 3'd3,
		REG_VP_H  = 3'd4,
		REG_WIN_W = 3'd5,
		REG_WIN_H = 3'd6
	} reg_idx_t;

endpackage

// ===== sv/vtv_div.sv =====
// ----------------------------------------------------------------------------
// vtv_div: staged unsigned divider
// Restoring long division, DIV_K quotient bits per register stage, with a
// valid bit and a side tag carried along. The divisor must stay stable while
// items are in flight and must be nonzero.
// ----------------------------------------------------------------------------
module vtv_div #(
	parameter int NW   = 47,
	parameter int TAGW = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [NW-1:0]             num,
	input  logic [vtv_pkg::WIN_W-1:0] den,
	input  logic [TAGW-1:0]           tag_in,
	output logic                      out_vld,
	output logic [((NW + vtv_pkg::DIV_K - 1) / vtv_pkg::DIV_K) * vtv_pkg::DIV_K - 1:0] quo,
	output logic [TAGW-1:0]           tag_out
);
	import vtv_pkg::*;

	localparam int S  = (NW + DIV_K - 1) / DIV_K;
	localparam int PW = S * DIV_K;
	localparam int DW = WIN_W;

	logic            vld_s [0:S];
	logic [DW-1:0]   rem_s [0:S-1];
	logic [PW-1:0]   acc_s [0:S];
	logic [TAGW-1:0] tag_s [0:S];

	// stage zero is the incoming item
	assign vld_s[0] = in_vld;
	assign rem_s[0] = '0;
	assign acc_s[0] = PW'(num);
	assign tag_s[0] = tag_in;

	for (genvar g = 0; g < S; g++) begin : g_stage
		logic [DW-1:0] rem_nx;
		logic [PW-1:0] acc_nx;

		// DIV_K shift and subtract steps
		always_comb begin
			logic [DW:0]   tr;
			logic [DW-1:0] r;
			logic [PW-1:0] a;
			r = rem_s[g];
			a = acc_s[g];
			tr = '0;
			for (int k = 0; k < DIV_K; k++) begin
				tr = {r, a[PW-1]};
				a = {a[PW-2:0], 1'b0};
				if (tr >= {1'b0, den}) begin
					tr = tr - {1'b0, den};
					a[0] = 1'b1;
				end
				r = tr[DW-1:0];
			end
			rem_nx = r;
			acc_nx = a;
		end

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[g+1] <= acc_nx;
				tag_s[g+1] <= tag_s[g];
			end
		end

		// remainder is dropped after the last stage
		if (g < S - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g+1] <= rem_nx;
				end
			end
		end
	end

	assign out_vld = vld_s[S];
	assign quo     = acc_s[S];
	assign tag_out = tag_s[S];

endmodule

// ===== sv/vertex_transform_viewport.sv =====
// Vertex transform and viewport mapping. Load items (op 0) write one element of
// the column-major 4x4 Q16.16 matrix and give no result; vertex items (op 1)
// accepted while draw_enable is set give one result: the x and y rows of
// M*(x,y,z,1), mapped through the viewport and renormalized against the window
// size, saturated to 32 bits, with the colour carried along. Vertices accepted
// while drawing is off are dropped. One item is accepted per clock while the
// skid register is empty; a result passes through six arithmetic stages (the
// first one loaded at the accepting edge), twelve divider stages (four quotient
// bits each, for the division by the window size), and the output register. A
// skid register behind the output catches a result that arrives while the
// output is stalled, so items are taken until it is full. Configuration may be
// written only while no item is in flight.
// ----------------------------------------------------------------------------
// vertex_transform_viewport: matrix transform and viewport mapping
// Matrix store, multiply and sum stages, viewport scaling, window divide,
// saturation and output skid register.
// ----------------------------------------------------------------------------
module vertex_transform_viewport #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// item input
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               op,
	input  logic [3:0]                         elem_index,
	input  logic signed [vtv_pkg::COORD_W-1:0] elem_value,
	input  logic signed [vtv_pkg::COORD_W-1:0] vert_x,
	input  logic signed [vtv_pkg::COORD_W-1:0] vert_y,
	input  logic signed [vtv_pkg::COORD_W-1:0] vert_z,
	input  logic [vtv_pkg::COLOR_W-1:0]        color_red,
	input  logic [vtv_pkg::COLOR_W-1:0]        color_green,
	input  logic [vtv_pkg::COLOR_W-1:0]        color_blue,
	// result output
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [vtv_pkg::COORD_W-1:0] screen_x,
	output logic signed [vtv_pkg::COORD_W-1:0] screen_y,
	output logic [vtv_pkg::COLOR_W-1:0]        out_red,
	output logic [vtv_pkg::COLOR_W-1:0]        out_green,
	output logic [vtv_pkg::COLOR_W-1:0]        out_blue,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [vtv_pkg::REG_AW-1:0]         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import vtv_pkg::*;

	// arithmetic widths
	localparam int RGB_W = 3 * COLOR_W;
	localparam int PSW   = 2 * COORD_W - FRAC_BITS;       // shifted product
	localparam int AW    = PSW + 1;                       // pair sum
	localparam int SW    = PSW + 2;                       // row sum
	localparam int MW    = (COORD_W + 1) + (WIN_W + 1);   // scaled coordinate
	localparam int OW    = VP_W + FRAC_BITS + 1;          // shifted origin
	localparam int TW    = ((OW > MW) ? OW : MW) + 1;     // twice viewport value
	localparam int NW    = TW - 1;                        // folded magnitude
	localparam int PW    = ((NW + DIV_K - 1) / DIV_K) * DIV_K;
	localparam int QW    = PW + 2;

	localparam logic signed [COORD_W:0] ONE_Q   = (COORD_W + 1)'(1) << FRAC_BITS;
	localparam logic signed [63:0]      SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0]      SAT_MIN = -64'sd2147483648;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
		if (v > SAT_MAX) begin
			return SAT_MAX[COORD_W-1:0];
		end else if (v < SAT_MIN) begin
			return SAT_MIN[COORD_W-1:0];
		end
		return v[COORD_W-1:0];
	endfunction

	// configuration registers, index 0 is the x axis and 1 the y axis
	logic               draw_en_q;
	logic [VP_W-1:0]    vp_org_q  [0:1];
	logic [WIN_W-1:0]   vp_size_q [0:1];
	logic [WIN_W-1:0]   win_q     [0:1];

	// matrix rows 0 and 1, columns 0..3; rows 2 and 3 never reach a result
	logic signed [COORD_W-1:0] m_q [0:1][0:3];

	logic en;
	logic cfg_wr;
	reg_idx_t reg_idx;

	// stage registers
	logic                      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [COORD_W-1:0] vin_s1  [0:2];
	logic [RGB_W-1:0]          rgb_s1, rgb_s2, rgb_s3, rgb_s4, rgb_s5, rgb_s6;
	logic signed [PSW-1:0]     prd_s2  [0:1][0:2];
	logic signed [COORD_W-1:0] bias_s2 [0:1];
	logic signed [AW-1:0]      sa_s3   [0:1];
	logic signed [AW-1:0]      sb_s3   [0:1];
	logic signed [COORD_W-1:0] p_s4    [0:1];
	logic signed [MW-1:0]      t1_s5   [0:1];
	logic [NW-1:0]             n_s6    [0:1];
	logic                      sgn_s6  [0:1];

	// stage inputs
	logic signed [PSW-1:0]     prd_nx  [0:1][0:2];
	logic signed [AW-1:0]      sa_nx   [0:1];
	logic signed [AW-1:0]      sb_nx   [0:1];
	logic signed [COORD_W-1:0] p_nx    [0:1];
	logic signed [MW-1:0]      t1_nx   [0:1];
	logic [NW-1:0]             n_nx    [0:1];
	logic                      sgn_nx  [0:1];
	logic [WIN_W-1:0]          den     [0:1];

	// divider outputs
	logic                      dvld    [0:1];
	logic [PW-1:0]             dq      [0:1];
	logic [RGB_W:0]            dtag_x;
	logic                      dtag_y;

	// final result
	logic                      rvld;
	logic signed [COORD_W-1:0] scr     [0:1];

	// output and skid registers
	logic                      o_vld_q, sk_vld_q;
	logic signed [COORD_W-1:0] o_x_q, o_y_q, sk_x_q, sk_y_q;
	logic [RGB_W-1:0]          o_rgb_q, sk_rgb_q;

	// whole datapath moves unless the skid register is occupied
	assign en       = !sk_vld_q;
	assign in_ready = en;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[REG_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_en_q    <= 1'b0;
			vp_org_q[0]  <= '0;
			vp_org_q[1]  <= '0;
			vp_size_q[0] <= WIN_W'(2);
			vp_size_q[1] <= WIN_W'(2);
			win_q[0]     <= WIN_W'(640);
			win_q[1]     <= WIN_W'(480);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_DRAW:  draw_en_q    <= pwdata[0];
				REG_VP_X:  vp_org_q[0]  <= pwdata[VP_W-1:0];
				REG_VP_Y:  vp_org_q[1]  <= pwdata[VP_W-1:0];
				REG_VP_W:  vp_size_q[0] <= pwdata[WIN_W-1:0];
				REG_VP_H:  vp_size_q[1] <= pwdata[WIN_W-1:0];
				REG_WIN_W: win_q[0]     <= pwdata[WIN_W-1:0];
				REG_WIN_H: win_q[1]     <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_DRAW:  prdata[0]          = draw_en_q;
			REG_VP_X:  prdata[VP_W-1:0]   = vp_org_q[0];
			REG_VP_Y:  prdata[VP_W-1:0]   = vp_org_q[1];
			REG_VP_W:  prdata[WIN_W-1:0]  = vp_size_q[0];
			REG_VP_H:  prdata[WIN_W-1:0]  = vp_size_q[1];
			REG_WIN_W: prdata[WIN_W-1:0]  = win_q[0];
			REG_WIN_H: prdata[WIN_W-1:0]  = win_q[1];
			default:   prdata             = '0;
		endcase
	end

	// matrix element load, only x and y rows are kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 2; r++) begin
				for (int c = 0; c < 4; c++) begin
					m_q[r][c] <= '0;
				end
			end
		end else if (in_valid && en && op == OP_LOAD && !elem_index[1]) begin
			m_q[elem_index[0]][elem_index[3:2]] <= elem_value;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid && op == OP_VERTEX && draw_en_q;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// products, floor shifted to fixed point
	always_comb begin
		logic signed [63:0] mul;
		mul = '0;
		for (int r = 0; r < 2; r++) begin
			for (int c = 0; c < 3; c++) begin
				mul = 64'(vin_s1[c]) * 64'(m_q[r][c]);
				prd_nx[r][c] = PSW'(mul >>> FRAC_BITS);
			end
		end
	end

	// row sums, saturation, viewport scale and origin, sign fold
	always_comb begin
		logic signed [SW-1:0]      sum;
		logic signed [COORD_W:0]   pone;
		logic signed [TW-1:0]      org;
		logic signed [TW-1:0]      tt;
		sum = '0;
		pone = '0;
		org = '0;
		tt = '0;
		for (int r = 0; r < 2; r++) begin
			sa_nx[r] = AW'(prd_s2[r][0]) + AW'(prd_s2[r][1]);
			sb_nx[r] = AW'(prd_s2[r][2]) + AW'(bias_s2[r]);
			sum = SW'(sa_s3[r]) + SW'(sb_s3[r]);
			p_nx[r] = sat32(64'(sum));
			pone = (COORD_W + 1)'(p_s4[r]) + ONE_Q;
			t1_nx[r] = MW'(pone) * MW'($signed({1'b0, vp_size_q[r]}));
			org = $signed(TW'(vp_org_q[r]) << (FRAC_BITS + 1));
			tt = TW'(t1_s5[r]) + org;
			// floor division of a negative value: ~floor(~t / d)
			n_nx[r] = tt[NW-1:0] ^ {NW{tt[TW-1]}};
			sgn_nx[r] = tt[TW-1];
			den[r] = (win_q[r] == '0) ? WIN_W'(1) : win_q[r];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			vin_s1[0] <= vert_x;
			vin_s1[1] <= vert_y;
			vin_s1[2] <= vert_z;
			rgb_s1    <= {color_red, color_green, color_blue};
			rgb_s2    <= rgb_s1;
			rgb_s3    <= rgb_s2;
			rgb_s4    <= rgb_s3;
			rgb_s5    <= rgb_s4;
			rgb_s6    <= rgb_s5;
			for (int r = 0; r < 2; r++) begin
				for (int c = 0; c < 3; c++) begin
					prd_s2[r][c] <= prd_nx[r][c];
				end
				bias_s2[r] <= m_q[r][3];
				sa_s3[r]   <= sa_nx[r];
				sb_s3[r]   <= sb_nx[r];
				p_s4[r]    <= p_nx[r];
				t1_s5[r]   <= t1_nx[r];
				n_s6[r]    <= n_nx[r];
				sgn_s6[r]  <= sgn_nx[r];
			end
		end
	end

	// division by window size, x lane carries the colour
	vtv_div #(
		.NW   (NW),
		.TAGW (RGB_W + 1)
	) u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s6),
		.num     (n_s6[0]),
		.den     (den[0]),
		.tag_in  ({sgn_s6[0], rgb_s6}),
		.out_vld (dvld[0]),
		.quo     (dq[0]),
		.tag_out (dtag_x)
	);

	vtv_div #(
		.NW   (NW),
		.TAGW (1)
	) u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s6),
		.num     (n_s6[1]),
		.den     (den[1]),
		.tag_in  (sgn_s6[1]),
		.out_vld (dvld[1]),
		.quo     (dq[1]),
		.tag_out (dtag_y)
	);

	// unfold sign, subtract one, saturate
	always_comb begin
		logic              sg;
		logic signed [PW:0] q;
		logic signed [QW-1:0] res;
		sg = 1'b0;
		q = '0;
		res = '0;
		rvld = dvld[0] && dvld[1];
		for (int r = 0; r < 2; r++) begin
			sg = (r == 0) ? dtag_x[RGB_W] : dtag_y;
			q = {sg, dq[r] ^ {PW{sg}}};
			res = QW'(q) - QW'(ONE_Q);
			scr[r] = sat32(64'(res));
		end
	end

	// output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q  <= 1'b0;
			sk_vld_q <= 1'b0;
		end else if (!o_vld_q || out_ready) begin
			o_vld_q  <= sk_vld_q || rvld;
			sk_vld_q <= 1'b0;
		end else if (rvld && !sk_vld_q) begin
			sk_vld_q <= 1'b1;
		end
	end

	// output register and skid payload
	always_ff @(posedge clk) begin
		if (!o_vld_q || out_ready) begin
			if (sk_vld_q) begin
				o_x_q   <= sk_x_q;
				o_y_q   <= sk_y_q;
				o_rgb_q <= sk_rgb_q;
			end else begin
				o_x_q   <= scr[0];
				o_y_q   <= scr[1];
				o_rgb_q <= dtag_x[RGB_W-1:0];
			end
		end else if (rvld && !sk_vld_q) begin
			sk_x_q   <= scr[0];
			sk_y_q   <= scr[1];
			sk_rgb_q <= dtag_x[RGB_W-1:0];
		end
	end

	assign out_valid = o_vld_q;
	assign screen_x  = o_x_q;
	assign screen_y  = o_y_q;
	assign out_red   = o_rgb_q[3*COLOR_W-1:2*COLOR_W];
	assign out_green = o_rgb_q[2*COLOR_W-1:COLOR_W];
	assign out_blue  = o_rgb_q[COLOR_W-1:0];

	// skid holds an item only behind an occupied output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_vld_q |-> o_vld_q)
		else $error("skid register full while output register empty");

	// a full skid register freezes the datapath
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		sk_vld_q |=> (vld_s1 == $past(vld_s1) && vld_s6 == $past(vld_s6)))
		else $error("datapath advanced during stall");

	// vertices are dropped while drawing is off
	a_draw_off_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && op == OP_VERTEX && !draw_en_q) |=> !vld_s1)
		else $error("vertex entered while drawing disabled");

	// a load of element zero lands in the matrix
	a_load_elem0: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && op == OP_LOAD && elem_index == 4'd0)
		|=> (m_q[0][0] == $past(elem_value)))
		else $error("matrix element load lost");

endmodule

// ===== bench/screen_coord_checker.sv =====
// ----------------------------------------------------------------------------
// screen_coord_checker: result checker for vertex_transform_viewport
// Follows register writes and the item channel, works out the screen
// coordinates of each drawn vertex, and compares them with the result channel.
// ----------------------------------------------------------------------------
module screen_coord_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic                               op,
	input  logic [3:0]                         elem_index,
	input  logic signed [vtv_pkg::COORD_W-1:0] elem_value,
	input  logic signed [vtv_pkg::COORD_W-1:0] vert_x,
	input  logic signed [vtv_pkg::COORD_W-1:0] vert_y,
	input  logic signed [vtv_pkg::COORD_W-1:0] vert_z,
	input  logic [vtv_pkg::COLOR_W-1:0]        color_red,
	input  logic [vtv_pkg::COLOR_W-1:0]        color_green,
	input  logic [vtv_pkg::COLOR_W-1:0]        color_blue,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [vtv_pkg::COORD_W-1:0] screen_x,
	input  logic signed [vtv_pkg::COORD_W-1:0] screen_y,
	input  logic [vtv_pkg::COLOR_W-1:0]        out_red,
	input  logic [vtv_pkg::COLOR_W-1:0]        out_green,
	input  logic [vtv_pkg::COLOR_W-1:0]        out_blue,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic                               pready,
	input  logic [vtv_pkg::REG_AW-1:0]         paddr,
	input  logic [31:0]                        pwdata,
	output int                                 fail_count,
	output int                                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import vtv_pkg::*;

	typedef struct packed {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic [COLOR_W-1:0]        red;
		logic [COLOR_W-1:0]        green;
		logic [COLOR_W-1:0]        blue;
	} screen_pt_t;

	localparam longint ONE_FX  = longint'(1) << FRAC_BITS;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	// local copy of the matrix and the register file
	logic signed [COORD_W-1:0] mat [16];
	logic                      draw_on;
	logic [VP_W-1:0]           org_x, org_y;
	logic [WIN_W-1:0]          size_w, size_h, win_w, win_h;

	// screen points still owed by the block, oldest first
	screen_pt_t projected_pts [$];
	screen_pt_t head;

	function automatic longint clamp_s32(longint v);
		if (v > S32_MAX)
			return S32_MAX;
		if (v < S32_MIN)
			return S32_MIN;
		return v;
	endfunction

	// division rounding toward minus infinity, divisor positive
	function automatic longint floor_quot(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q -= 1;
		return q;
	endfunction

	// one row of M * (x, y, z, 1), each product floored to the fixed point
	function automatic longint row_coord(int row, longint x, longint y, longint z);
		longint acc;
		acc = ((x * longint'(mat[row])) >>> FRAC_BITS)
			+ ((y * longint'(mat[row + 4])) >>> FRAC_BITS)
			+ ((z * longint'(mat[row + 8])) >>> FRAC_BITS)
			+ longint'(mat[row + 12]);
		return clamp_s32(acc);
	endfunction

	// viewport scaling then window renormalization
	function automatic longint viewport_axis(longint p, longint size, longint origin,
		longint win);
		longint t;
		longint d;
		t = (p + ONE_FX) * size + (origin <<< (FRAC_BITS + 1));
		d = (win == 0) ? 1 : win;
		return clamp_s32(floor_quot(t, d) - ONE_FX);
	endfunction

	function automatic screen_pt_t project_vertex(longint x, longint y, longint z,
		logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
		screen_pt_t pt;
		longint     ax, ay;
		ax = viewport_axis(row_coord(0, x, y, z), longint'(size_w), longint'(org_x),
			longint'(win_w));
		ay = viewport_axis(row_coord(1, x, y, z), longint'(size_h), longint'(org_y),
			longint'(win_h));
		pt.sx    = ax[COORD_W-1:0];
		pt.sy    = ay[COORD_W-1:0];
		pt.red   = r;
		pt.green = g;
		pt.blue  = b;
		return pt;
	endfunction

	task automatic cmp_field(string name, logic signed [63:0] want, logic signed [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (mat[i])
				mat[i] = '0;
			draw_on = 1'b0;
			org_x   = '0;
			org_y   = '0;
			size_w  = 13'd2;
			size_h  = 13'd2;
			win_w   = 13'd640;
			win_h   = 13'd480;
			projected_pts.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[REG_AW-1:2]))
					REG_DRAW:  draw_on = pwdata[0];
					REG_VP_X:  org_x   = pwdata[VP_W-1:0];
					REG_VP_Y:  org_y   = pwdata[VP_W-1:0];
					REG_VP_W:  size_w  = pwdata[WIN_W-1:0];
					REG_VP_H:  size_h  = pwdata[WIN_W-1:0];
					REG_WIN_W: win_w   = pwdata[WIN_W-1:0];
					REG_WIN_H: win_h   = pwdata[WIN_W-1:0];
					default: ;
				endcase
			end

			// result side
			if (out_valid && out_ready) begin
				if (projected_pts.size() == 0) begin
					$display("%0t: result x %0d y %0d with no vertex outstanding",
						$time, screen_x, screen_y);
					fail_count++;
				end else begin
					head = projected_pts.pop_front();
					cmp_field("screen_x", head.sx, screen_x);
					cmp_field("screen_y", head.sy, screen_y);
					cmp_field("out_red", {56'd0, head.red}, {56'd0, out_red});
					cmp_field("out_green", {56'd0, head.green}, {56'd0, out_green});
					cmp_field("out_blue", {56'd0, head.blue}, {56'd0, out_blue});
				end
			end

			// item side: loads update the matrix, drawn vertices owe a result
			if (in_valid && in_ready) begin
				if (op_t'(op) == OP_LOAD)
					mat[elem_index] = elem_value;
				else if (draw_on)
					projected_pts.insert(projected_pts.size(),
						project_vertex(longint'(vert_x),
						longint'(vert_y), longint'(vert_z),
						color_red, color_green, color_blue));
			end

			pending = projected_pts.size();
		end
	end

endmodule

// ===== bench/tb_vertex_transform_viewport.sv =====
// ----------------------------------------------------------------------------
// tb_vertex_transform_viewport: testbench for the vertex transform block
// Loads matrices and streams vertices through a sequence of viewport and
// window settings, with random gaps and stalls on both channels and one long
// output hold-off; results are checked by screen_coord_checker.
// ----------------------------------------------------------------------------
module tb_vertex_transform_viewport;
	timeunit 1ns;
	timeprecision 1ps;

	import vtv_pkg::*;

	localparam int FRAC_BITS      = 16;
	localparam int ONE            = 1 << FRAC_BITS;
	localparam int DRAIN_CYCLES   = 24;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam logic signed [COORD_W-1:0] FX_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] FX_MIN = 32'sh8000_0000;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      op;
	logic [3:0]                elem_index;
	logic signed [COORD_W-1:0] elem_value;
	logic signed [COORD_W-1:0] vert_x, vert_y, vert_z;
	logic [COLOR_W-1:0]        color_red, color_green, color_blue;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [COORD_W-1:0] screen_x, screen_y;
	logic [COLOR_W-1:0]        out_red, out_green, out_blue;
	logic                      psel, penable, pwrite;
	logic [REG_AW-1:0]         paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;

	int          fail_count;
	int          pending;
	int unsigned tx_gap_pct = 0;
	int unsigned rx_gap_pct = 0;
	bit          hold_rx = 1'b0;
	int unsigned idle_cycles = 0;

	vertex_transform_viewport #(.FRAC_BITS(FRAC_BITS)) i_dut (.*);

	screen_coord_checker #(.FRAC_BITS(FRAC_BITS)) i_checker (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_rx = 1'b0;
				out_ready <= 1'b1;
			end else if (rx_gap_pct != 0 && $urandom_range(1, 100) <= rx_gap_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else
				out_ready <= 1'b1;
		end
	end

	// mostly small values around zero, now and then full range or an extreme
	function automatic logic signed [COORD_W-1:0] rand_fix();
		case ($urandom_range(0, 31))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 5))
					0:       return FX_MAX;
					1:       return FX_MIN;
					2:       return 0;
					3:       return -1;
					4:       return ONE;
					default: return -ONE;
				endcase
			end
			default: return int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
		endcase
	endfunction

	// offer one item, hold it until taken
	task automatic send_item(op_t o, logic [3:0] idx, logic signed [COORD_W-1:0] ev,
		logic signed [COORD_W-1:0] vx, logic signed [COORD_W-1:0] vy,
		logic signed [COORD_W-1:0] vz, logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
		logic [COLOR_W-1:0] b);
		if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		op          <= o;
		elem_index  <= idx;
		elem_value  <= ev;
		vert_x      <= vx;
		vert_y      <= vy;
		vert_z      <= vz;
		color_red   <= r;
		color_green <= g;
		color_blue  <= b;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// stop offering and let every outstanding vertex leave the block
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// register write: setup cycle, then access cycle
	task automatic reg_write(reg_idx_t r, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// one setting of all registers followed by random items
	task automatic run_phase(logic [31:0] draw, logic [31:0] vx, logic [31:0] vy,
		logic [31:0] vw, logic [31:0] vh, logic [31:0] ww, logic [31:0] wh,
		int n, int unsigned txp, int unsigned rxp, bit hold);
		wait_drained();
		reg_write(REG_DRAW, draw);
		reg_write(REG_VP_X, vx);
		reg_write(REG_VP_Y, vy);
		reg_write(REG_VP_W, vw);
		reg_write(REG_VP_H, vh);
		reg_write(REG_WIN_W, ww);
		reg_write(REG_WIN_H, wh);
		tx_gap_pct = txp;
		rx_gap_pct = rxp;
		if (hold)
			hold_rx = 1'b1;
		repeat (n)
			send_item(($urandom_range(0, 3) == 0) ? OP_LOAD : OP_VERTEX, 4'($urandom),
				rand_fix(), rand_fix(), rand_fix(), rand_fix(),
				8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// stimulus
	initial begin
		in_valid    = 1'b0;
		op          = OP_LOAD;
		elem_index  = '0;
		elem_value  = '0;
		vert_x      = '0;
		vert_y      = '0;
		vert_z      = '0;
		color_red   = '0;
		color_green = '0;
		color_blue  = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		arst_n      = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// vertex while drawing is off is dropped
		send_item(OP_VERTEX, 4'd0, 0, ONE, ONE, ONE, 8'd1, 8'd2, 8'd3);
		wait_drained();
		reg_write(REG_DRAW, 32'd1);

		// identity matrix, reset viewport and window
		send_item(OP_LOAD, 4'd0, ONE, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		send_item(OP_LOAD, 4'd5, ONE, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		send_item(OP_LOAD, 4'd10, ONE, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		send_item(OP_LOAD, 4'd15, ONE, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		send_item(OP_VERTEX, 4'd0, 0, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		send_item(OP_VERTEX, 4'd0, 0, ONE, -ONE, 0, 8'd255, 8'd255, 8'd255);
		send_item(OP_VERTEX, 4'd0, 0, FX_MAX, FX_MIN, FX_MAX, 8'd17, 8'd34, 8'd51);
		send_item(OP_VERTEX, 4'd0, 0, -1, -1, 0, 8'd128, 8'd64, 8'd32);

		// largest elements drive the x row into saturation both ways
		send_item(OP_LOAD, 4'd0, FX_MAX, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		send_item(OP_LOAD, 4'd4, FX_MAX, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		send_item(OP_LOAD, 4'd8, FX_MAX, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		send_item(OP_VERTEX, 4'd0, 0, FX_MAX, FX_MAX, FX_MAX, 8'd1, 8'd254, 8'd127);
		send_item(OP_VERTEX, 4'd0, 0, FX_MIN, FX_MIN, FX_MIN, 8'd254, 8'd1, 8'd128);

		// most negative elements and translation terms
		send_item(OP_LOAD, 4'd1, FX_MIN, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		send_item(OP_LOAD, 4'd13, FX_MIN, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		send_item(OP_LOAD, 4'd12, FX_MAX, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		send_item(OP_VERTEX, 4'd0, 0, FX_MIN, FX_MAX, 0, 8'd85, 8'd170, 8'd0);
		send_item(OP_VERTEX, 4'd0, 0, FX_MAX, FX_MIN, -1, 8'd170, 8'd85, 8'd255);

		// elements outside the x and y rows have no effect
		send_item(OP_LOAD, 4'd3, FX_MAX, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		send_item(OP_LOAD, 4'd14, FX_MIN, 0, 0, 0, 8'd0, 8'd0, 8'd0);
		send_item(OP_VERTEX, 4'd0, 0, 3, -7, 11, 8'd9, 8'd99, 8'd199);

		// register settings: reset-like, upper extremes, lower extremes, beyond
		// range with zero window, drawing off, random, full-width random, gapless random
		run_phase(1, 0, 0, 2, 2, 640, 480, 200, 0, 0, 1'b0);
		run_phase(1, 4095, 4095, 4096, 4096, 4096, 4096, 200, 20, 20, 1'b1);
		run_phase(1, 0, 0, 0, 0, 1, 1, 200, 10, 40, 1'b0);
		run_phase(1, 4095, 0, 8191, 8191, 0, 0, 200, 40, 10, 1'b0);
		run_phase(0, $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(1, 4096), $urandom_range(1, 4096),
			$urandom_range(1, 4096), $urandom_range(1, 4096), 80, 20, 20, 1'b0);
		run_phase(1, $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(1, 4096), $urandom_range(1, 4096),
			$urandom_range(1, 4096), $urandom_range(1, 4096), 280, 25, 25, 1'b0);
		run_phase($urandom | 32'd1, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, 280, 15, 30, 1'b0);
		run_phase(1, $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(1, 4096), $urandom_range(1, 4096),
			$urandom_range(1, 4096), $urandom_range(1, 4096), 280, 0, 0, 1'b0);

		// verdict
		wait_drained();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
